// File: rtl/core/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types, constants and divider helpers of the 3x3 box blur core.
// ----------------------------------------------------------------------------
package bb3_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;

	localparam int CHAN_W       = 8;
	localparam int PIX_W        = 3 * CHAN_W;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int CFG_DATA_W   = 13;

	localparam logic [WIDTH_REG_W-1:0]  RST_FRAME_WIDTH  = 11'd640;
	localparam logic [HEIGHT_REG_W-1:0] RST_FRAME_HEIGHT = 13'd480;

	// sum of up to nine channel values, doubled sum plus count, halved
	localparam int SUM_W       = 12;
	localparam int X_W         = 13;
	localparam int Y_W         = 12;
	localparam int N_W         = 4;
	localparam int RECIP_W     = 20;
	localparam int RECIP_SHIFT = 19;
	localparam int PROD_W      = Y_W + RECIP_W;
	localparam int Q_W         = PROD_W - RECIP_SHIFT;

	localparam logic [RECIP_W-1:0] RECIP_ONE   = 20'd524288;
	localparam logic [RECIP_W-1:0] RECIP_THIRD = 20'd174763;
	localparam logic [RECIP_W-1:0] RECIP_NINTH = 20'd58255;

	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

	typedef enum logic {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_idx_t;

	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [PIX_W-1:0]  pixel_t;

	typedef struct packed {
		logic top_ok;
		logic bottom_ok;
		logic left_ok;
		logic right_ok;
		logic last;
	} border_t;

	typedef struct packed {
		logic    take;
		logic    flush;
		logic    upd;
		logic    sum;
		logic    load_out;
		border_t border;
	} bb3_cmd_t;

	typedef struct packed {
		logic out_free;
	} bb3_status_t;

	// divide by 2n as a shift by the power of two in 2n, then by 1, 3 or 9
	function automatic logic [1:0] div_shift(logic [N_W-1:0] n);
		case (n)
			4'd2, 4'd6: return 2'd2;
			4'd4:       return 2'd3;
			default:    return 2'd1;
		endcase
	endfunction

	function automatic logic [RECIP_W-1:0] div_recip(logic [N_W-1:0] n);
		case (n)
			4'd3, 4'd6: return RECIP_THIRD;
			4'd9:       return RECIP_NINTH;
			default:    return RECIP_ONE;
		endcase
	endfunction

endpackage

// File: rtl/core/bb3_in_if.sv
// ----------------------------------------------------------------------------
// bb3_in_if
// Pixel input channel: valid/ready handshake with mode and RGB payload.
// ----------------------------------------------------------------------------
interface bb3_in_if;
	import bb3_pkg::*;

	logic  valid;
	logic  ready;
	logic  mode;
	chan_t red_in;
	chan_t green_in;
	chan_t blue_in;

	modport source (output valid, output mode, output red_in, output green_in,
		output blue_in, input ready);
	modport sink (input valid, input mode, input red_in, input green_in,
		input blue_in, output ready);

endinterface

// File: rtl/core/bb3_out_if.sv
// ----------------------------------------------------------------------------
// bb3_out_if
// Blurred pixel output channel: valid/ready handshake with RGB and frame end.
// ----------------------------------------------------------------------------
interface bb3_out_if;
	import bb3_pkg::*;

	logic  valid;
	logic  ready;
	chan_t red_out;
	chan_t green_out;
	chan_t blue_out;
	logic  frame_last;

	modport source (output valid, output red_out, output green_out, output blue_out,
		output frame_last, input ready);
	modport sink (input valid, input red_out, input green_out, input blue_out,
		input frame_last, output ready);

endinterface

// File: rtl/core/bb3_ram.sv
// ----------------------------------------------------------------------------
// bb3_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bb3_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/core/bb3_ctrl.sv
// ----------------------------------------------------------------------------
// bb3_ctrl
// Sequencer: frame registers, raster counters, border flags and step control.
// ----------------------------------------------------------------------------
module bb3_ctrl #(
	parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT,
	parameter int AW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_mode,
	output logic                            in_ready,
	input  logic                            cfg_wr_en,
	input  bb3_pkg::cfg_idx_t               cfg_index,
	input  logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
	input  bb3_pkg::bb3_status_t            status,
	output bb3_pkg::bb3_cmd_t               cmd,
	output logic [AW-1:0]                   addr
);
	import bb3_pkg::*;

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 2);

	typedef enum logic [1:0] {
		S_IDLE,
		S_UPD,
		S_SUM,
		S_DIV
	} state_t;

	function automatic logic [WW-1:0] clamp_width(logic [WIDTH_REG_W-1:0] raw);
		if (raw == '0) return WW'(1);
		if (32'(raw) > 32'(MAX_WIDTH)) return WW'(MAX_WIDTH);
		return WW'(raw);
	endfunction

	function automatic logic [RW-1:0] clamp_height(logic [HEIGHT_REG_W-1:0] raw);
		if (raw == '0) return RW'(1);
		if (32'(raw) > 32'(MAX_HEIGHT)) return RW'(MAX_HEIGHT);
		return RW'(raw);
	endfunction

	state_t        state_q;
	logic [WW-1:0] width_q;
	logic [RW-1:0] height_q;
	logic [WW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [AW-1:0] addr_q;
	logic          emit_q;
	border_t       border_q;

	logic          in_frame;
	logic          take;
	logic          emit;
	logic          wrap;
	logic          col_zero;
	logic [WW-1:0] col_inc;
	logic [RW-1:0] row_inc;
	logic [RW-1:0] ctr_row;
	logic [WW-1:0] ctr_col;
	logic [RW-1:0] hm1;
	logic [WW-1:0] wm1;
	border_t       border_c;

	always_comb begin
		in_frame = row_q < height_q;
		in_ready = state_q == S_IDLE;
		// a drain beat before the frame is complete is accepted and dropped, not taken
		take     = in_valid && in_ready && !(in_frame && in_mode);
		col_zero = col_q == '0;
		col_inc  = col_q + WW'(1);
		row_inc  = row_q + RW'(1);
		wrap     = col_inc >= width_q;
		emit     = (row_q >= RW'(2)) || (row_q == RW'(1) && !col_zero);
		hm1      = height_q - RW'(1);
		wm1      = width_q - WW'(1);
		// centre of the result: end of the row before last on a new row
		ctr_row  = col_zero ? row_q - RW'(2) : row_q - RW'(1);
		ctr_col  = col_zero ? wm1 : col_q - WW'(1);
		border_c.top_ok    = ctr_row != '0;
		border_c.bottom_ok = ctr_row < hm1;
		border_c.left_ok   = ctr_col != '0;
		border_c.right_ok  = ctr_col < wm1;
		border_c.last      = (ctr_row == hm1) && (ctr_col == wm1);
	end

	always_comb begin
		cmd.take     = take;
		cmd.flush    = !in_frame;
		cmd.upd      = state_q == S_UPD;
		cmd.sum      = state_q == S_SUM;
		cmd.load_out = (state_q == S_DIV) && status.out_free;
		cmd.border   = border_q;
		addr         = (state_q == S_IDLE) ? col_q[AW-1:0] : addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			width_q  <= clamp_width(RST_FRAME_WIDTH);
			height_q <= clamp_height(RST_FRAME_HEIGHT);
			col_q    <= '0;
			row_q    <= '0;
			addr_q   <= '0;
			emit_q   <= 1'b0;
			border_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (take) begin
						addr_q   <= col_q[AW-1:0];
						emit_q   <= emit;
						border_q <= border_c;
						state_q  <= S_UPD;
					end
				end
				S_UPD: begin
					state_q <= emit_q ? S_SUM : S_IDLE;
				end
				S_SUM: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (status.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// any register write restarts the frame
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_FRAME_WIDTH:  width_q  <= clamp_width(cfg_wr_data[WIDTH_REG_W-1:0]);
					CFG_FRAME_HEIGHT: height_q <= clamp_height(cfg_wr_data[HEIGHT_REG_W-1:0]);
					default: ;
				endcase
				col_q <= '0;
				row_q <= '0;
			end else if (take) begin
				if (emit && border_c.last) begin
					col_q <= '0;
					row_q <= '0;
				end else if (wrap) begin
					col_q <= '0;
					row_q <= row_inc;
				end else begin
					col_q <= col_inc;
				end
			end
		end
	end

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q < width_q)
		else $error("column counter beyond frame width");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= height_q + RW'(1))
		else $error("row counter ran past the flush rows");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(take && emit && border_c.last && !cfg_wr_en) |=> (col_q == '0 && row_q == '0))
		else $error("frame end did not restart the raster counters");

	a_result_needs_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> emit_q)
		else $error("result loaded for a beat that gives none");

endmodule

// File: rtl/core/bb3_dp.sv
// ----------------------------------------------------------------------------
// bb3_dp
// Datapath: line stores, 3x3 window, masked sums, rounded mean, output reg.
// ----------------------------------------------------------------------------
module bb3_dp #(
	parameter int MAX_WIDTH = bb3_pkg::DEF_MAX_WIDTH,
	parameter int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bb3_pkg::bb3_cmd_t     cmd,
	input  logic [AW-1:0]         addr,
	input  bb3_pkg::chan_t        red_in,
	input  bb3_pkg::chan_t        green_in,
	input  bb3_pkg::chan_t        blue_in,
	output bb3_pkg::bb3_status_t  status,
	output logic                  out_valid,
	input  logic                  out_ready,
	output bb3_pkg::chan_t        red_out,
	output bb3_pkg::chan_t        green_out,
	output bb3_pkg::chan_t        blue_out,
	output logic                  frame_last
);
	import bb3_pkg::*;

	pixel_t pix_q;
	pixel_t top_rd;
	pixel_t mid_rd;
	pixel_t win_q [3][3];

	logic [2:0]         row_ok;
	logic [2:0]         col_ok;
	logic [1:0]         n_rows;
	logic [1:0]         n_cols;
	logic [N_W-1:0]     n_c;
	logic [1:0]         shift_c;
	logic [SUM_W-1:0]   sum_c [3];
	logic [X_W-1:0]     x_c [3];
	logic [Y_W-1:0]     y_s1 [3];
	logic [RECIP_W-1:0] recip_s1;
	logic [PROD_W-1:0]  prod_c [3];
	logic [Q_W-1:0]     q_c [3];
	chan_t              mean_c [3];

	logic  out_valid_q;
	chan_t red_q;
	chan_t green_q;
	chan_t blue_q;
	logic  last_q;

	bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH), .AW(AW)) u_upper_ram (
		.clk    (clk),
		.wr_en  (cmd.upd),
		.wr_addr(addr),
		.wr_data(mid_rd),
		.rd_en  (cmd.take),
		.rd_addr(addr),
		.rd_data(top_rd)
	);

	bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH), .AW(AW)) u_middle_ram (
		.clk    (clk),
		.wr_en  (cmd.upd),
		.wr_addr(addr),
		.wr_data(pix_q),
		.rd_en  (cmd.take),
		.rd_addr(addr),
		.rd_data(mid_rd)
	);

	// window columns: 0 oldest, 2 newest; rows: 0 top
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			pix_q <= cmd.flush ? '0 : {red_in, green_in, blue_in};
		end
		if (cmd.upd) begin
			for (int rr = 0; rr < 3; rr++) begin
				win_q[rr][0] <= win_q[rr][1];
				win_q[rr][1] <= win_q[rr][2];
			end
			win_q[0][2] <= top_rd;
			win_q[1][2] <= mid_rd;
			win_q[2][2] <= pix_q;
		end
	end

	always_comb begin
		row_ok  = {cmd.border.bottom_ok, 1'b1, cmd.border.top_ok};
		col_ok  = {cmd.border.right_ok, 1'b1, cmd.border.left_ok};
		n_rows  = 2'd1 + {1'b0, cmd.border.top_ok} + {1'b0, cmd.border.bottom_ok};
		n_cols  = 2'd1 + {1'b0, cmd.border.left_ok} + {1'b0, cmd.border.right_ok};
		n_c     = {2'b00, n_rows} * {2'b00, n_cols};
		shift_c = div_shift(n_c);
		for (int ch = 0; ch < 3; ch++) begin
			sum_c[ch] = '0;
			for (int rr = 0; rr < 3; rr++) begin
				for (int cc = 0; cc < 3; cc++) begin
					if (row_ok[rr] && col_ok[cc]) begin
						sum_c[ch] = sum_c[ch]
							+ SUM_W'(win_q[rr][cc][PIX_W-1-CHAN_W*ch -: CHAN_W]);
					end
				end
			end
			// half rounds up: (2*sum + n) / (2*n)
			x_c[ch] = {sum_c[ch], 1'b0} + X_W'(n_c);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			for (int ch = 0; ch < 3; ch++) begin
				y_s1[ch] <= Y_W'(x_c[ch] >> shift_c);
			end
			recip_s1 <= div_recip(n_c);
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			prod_c[ch] = PROD_W'(y_s1[ch]) * PROD_W'(recip_s1);
			q_c[ch]    = prod_c[ch][PROD_W-1:RECIP_SHIFT];
			mean_c[ch] = (q_c[ch] > Q_W'(CHAN_MAX)) ? CHAN_MAX : q_c[ch][CHAN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			red_q   <= mean_c[0];
			green_q <= mean_c[1];
			blue_q  <= mean_c[2];
			last_q  <= cmd.border.last;
		end
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign red_out         = red_q;
	assign green_out       = green_q;
	assign blue_out        = blue_q;
	assign frame_last      = last_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("waiting result overwritten");

endmodule

// File: rtl/core/box_blur_3x3_stream_core.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_stream_core
// Streaming 3x3 box blur of 24-bit RGB pixels in raster order.
// ----------------------------------------------------------------------------
// pixels carries one beat per raster step: mode 0 with RGB data, mode 1 a
// drain step. blurred carries one result beat per output pixel, frame_last
// set on the last pixel of the frame. A result for the pixel one row and one
// column behind leaves on each step from the second pixel of the second row
// on; after the frame width+1 drain beats flush the tail. Drain beats arriving
// before the frame is complete are accepted and dropped.
// Every beat that is kept makes one read and one write pass over the two line
// RAMs: a beat with no result goes through RAM read and window update, a beat
// with a result also through masked sum and reciprocal multiply, and its
// result is loaded into the output register of blurred at the multiply step.
// The result sits in an output register, so the next beat is taken while it
// waits; if it is still held when the next result is ready, the sequencer
// waits there and pixels.ready stays low.
// Reset sets width 640, height 480 and restarts the frame; line RAM contents
// are undefined until written. Any cfg write restarts the frame and must only
// come while the core is idle.
// ----------------------------------------------------------------------------
module box_blur_3x3_stream_core #(
	parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	bb3_in_if.sink                         pixels,
	bb3_out_if.source                      blurred,
	input  logic                           cfg_wr_en,
	input  bb3_pkg::cfg_idx_t              cfg_index,
	input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
	import bb3_pkg::*;

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	bb3_cmd_t      cmd;
	bb3_status_t   status;
	logic [AW-1:0] addr;
	logic          in_ready;

	bb3_ctrl #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.AW        (AW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (pixels.valid),
		.in_mode    (pixels.mode),
		.in_ready   (in_ready),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wr_data(cfg_wr_data),
		.status     (status),
		.cmd        (cmd),
		.addr       (addr)
	);

	bb3_dp #(
		.MAX_WIDTH(MAX_WIDTH),
		.AW       (AW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.addr      (addr),
		.red_in    (pixels.red_in),
		.green_in  (pixels.green_in),
		.blue_in   (pixels.blue_in),
		.status    (status),
		.out_valid (blurred.valid),
		.out_ready (blurred.ready),
		.red_out   (blurred.red_out),
		.green_out (blurred.green_out),
		.blue_out  (blurred.blue_out),
		.frame_last(blurred.frame_last)
	);

	assign pixels.ready = in_ready;

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming 3x3 box blur core. Beats are queued
// per frame setting and driven with random gaps; every accepted pixel beat
// runs through a bit-exact model of the line stores and window, and each
// blurred beat is compared with the oldest predicted pixel.
// ----------------------------------------------------------------------------
module tb;
	import bb3_pkg::*;

	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_DRAIN = 1'b1;
	localparam int   RAND_ITEMS = 1150;
	localparam int   MAX_ERR_PRINT = 40;
	// about 1.4k beats, each with random gaps on both the input and the output side
	localparam int   LIMIT_CYCLES = 1_000_000;

	typedef struct packed {
		logic  mode;
		chan_t red;
		chan_t green;
		chan_t blue;
	} beat_t;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
		logic  last;
	} blur_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  in_valid = 1'b0;
	beat_t                 in_beat = '0;
	logic                  out_ready = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	cfg_idx_t              cfg_index = CFG_FRAME_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

	bb3_in_if  pix_if ();
	bb3_out_if blur_if ();

	assign pix_if.valid    = in_valid;
	assign pix_if.mode     = in_beat.mode;
	assign pix_if.red_in   = in_beat.red;
	assign pix_if.green_in = in_beat.green;
	assign pix_if.blue_in  = in_beat.blue;
	assign blur_if.ready   = out_ready;

	box_blur_3x3_stream_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixels      (pix_if),
		.blurred     (blur_if),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// model state
	logic [WIDTH_REG_W-1:0]  width_reg = RST_FRAME_WIDTH;
	logic [HEIGHT_REG_W-1:0] height_reg = RST_FRAME_HEIGHT;
	pixel_t      upper_mem [DEF_MAX_WIDTH];
	pixel_t      middle_mem [DEF_MAX_WIDTH];
	pixel_t      win [9];
	int unsigned col_cnt = 0;
	int unsigned row_cnt = 0;
	int unsigned out_cnt = 0;

	beat_t beat_q [$];
	blur_t blur_q [$];

	int unsigned sent_cnt = 0;
	int unsigned taken_cnt = 0;
	int unsigned rand_items = 0;
	int unsigned err_cnt = 0;
	int unsigned results_ok = 0;
	int unsigned frames_done = 0;
	int unsigned cfg_writes = 0;
	int unsigned cycle_cnt = 0;

	int unsigned gap_left = 0;
	int unsigned quiet_in = 0;
	int unsigned stall_left = 0;
	int unsigned quiet_out = 0;
	blur_t       exp_res;

	function automatic int unsigned eff_dim(input int unsigned raw, input int unsigned hi);
		if (raw == 0)
			return 1;
		return (raw > hi) ? hi : raw;
	endfunction

	function automatic int unsigned pick_gap(input bit quiet);
		int unsigned roll;
		if (quiet)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic chan_t rand_chan();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return CHAN_MAX;
			default: return chan_t'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic beat_t rand_beat(input logic mode);
		return '{mode, rand_chan(), rand_chan(), rand_chan()};
	endfunction

	function automatic void check_field(input string name, input int unsigned exp_v,
		input int unsigned act_v);
		if (exp_v != act_v) begin
			err_cnt++;
			if (err_cnt <= MAX_ERR_PRINT)
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v,
					act_v);
		end
	endfunction

	task automatic predict_blur(input beat_t b);
		int unsigned w, h, ci, ri, n;
		int unsigned acc [3];
		int unsigned v [3];
		int r0, c0, wc, col;
		pixel_t px, top_px, mid_px, sel;
		pixel_t prev_win [9];
		pixel_t src [9];
		blur_t res;
		w = eff_dim(width_reg, DEF_MAX_WIDTH);
		h = eff_dim(height_reg, DEF_MAX_HEIGHT);
		ri = row_cnt;
		ci = col_cnt;
		// drain beat while the frame is still coming in: dropped
		if (ri < h && b.mode == MODE_DRAIN)
			return;
		px = (ri < h) ? {b.red, b.green, b.blue} : '0;
		prev_win = win;
		top_px = upper_mem[ci];
		mid_px = middle_mem[ci];
		upper_mem[ci] = mid_px;
		middle_mem[ci] = px;
		for (int k = 0; k < 3; k++) begin
			win[k * 3] = win[k * 3 + 1];
			win[k * 3 + 1] = win[k * 3 + 2];
		end
		win[2] = top_px;
		win[5] = mid_px;
		win[8] = px;
		col_cnt = ci + 1;
		if (col_cnt >= w) begin
			col_cnt = 0;
			row_cnt = ri + 1;
		end
		if (!(ri >= 2 || (ri == 1 && ci >= 1)))
			return;
		// column 0 step: centre sits at the row end, two rows up, in the old window
		if (ci >= 1) begin
			src = win;
			wc = 1;
			r0 = int'(ri) - 1;
			c0 = int'(ci) - 1;
		end else begin
			src = prev_win;
			wc = 2;
			r0 = int'(ri) - 2;
			c0 = int'(w) - 1;
		end
		acc = '{0, 0, 0};
		n = 0;
		for (int dr = -1; dr <= 1; dr++) begin
			if (r0 + dr < 0 || r0 + dr >= int'(h))
				continue;
			for (int dc = -1; dc <= 1; dc++) begin
				col = wc + dc;
				if (c0 + dc < 0 || c0 + dc >= int'(w) || col < 0 || col > 2)
					continue;
				sel = src[(dr + 1) * 3 + col];
				acc[0] += sel[23:16];
				acc[1] += sel[15:8];
				acc[2] += sel[7:0];
				n++;
			end
		end
		if (n == 0)
			n = 1;
		for (int k = 0; k < 3; k++) begin
			v[k] = (2 * acc[k] + n) / (2 * n);
			if (v[k] > 255)
				v[k] = 255;
		end
		res.red = chan_t'(v[0]);
		res.green = chan_t'(v[1]);
		res.blue = chan_t'(v[2]);
		if (out_cnt + 1 >= w * h) begin
			res.last = 1'b1;
			col_cnt = 0;
			row_cnt = 0;
			out_cnt = 0;
		end else begin
			res.last = 1'b0;
			out_cnt++;
		end
		blur_q.push_back(res);
	endtask

	task automatic queue_beat(input beat_t b, input bit counted);
		beat_q.push_back(b);
		sent_cnt++;
		if (counted)
			rand_items++;
	endtask

	// whole frame plus its flush; noisy adds early drains and pixels in the flush
	task automatic queue_frame(input int unsigned w, input int unsigned h, input bit noisy,
		input bit counted);
		for (int unsigned p = 0; p < w * h; p++) begin
			if (noisy && $urandom_range(0, 14) == 0)
				queue_beat(rand_beat(MODE_DRAIN), 1'b0);
			queue_beat(rand_beat(MODE_PIXEL), counted);
		end
		for (int unsigned p = 0; p <= w; p++) begin
			if (noisy && $urandom_range(0, 7) == 0)
				queue_beat(rand_beat(MODE_PIXEL), counted);
			else
				queue_beat(rand_beat(MODE_DRAIN), counted);
		end
	endtask

	task automatic wait_idle();
		while (taken_cnt != sent_cnt || blur_q.size() != 0)
			@(posedge clk);
		// beats with no result may still be in the pipe
		repeat (8) @(posedge clk);
	endtask

	task automatic set_frame(input int unsigned w_raw, input int unsigned h_raw);
		logic [CFG_DATA_W-1:0] wdata;
		// bits above the width register are junk and must be ignored
		wdata = CFG_DATA_W'(w_raw) | (CFG_DATA_W'($urandom_range(0, 3)) << WIDTH_REG_W);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_FRAME_WIDTH;
		cfg_wr_data <= wdata;
		width_reg = wdata[WIDTH_REG_W-1:0];
		@(posedge clk);
		cfg_index <= CFG_FRAME_HEIGHT;
		cfg_wr_data <= CFG_DATA_W'(h_raw);
		height_reg = HEIGHT_REG_W'(h_raw);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		col_cnt = 0;
		row_cnt = 0;
		out_cnt = 0;
		cfg_writes += 2;
	endtask

	// pixel driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && pix_if.ready) begin
				predict_blur(in_beat);
				taken_cnt++;
			end
			if (!in_valid || pix_if.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (beat_q.size() != 0) begin
					in_beat <= beat_q.pop_front();
					in_valid <= 1'b1;
					if (quiet_in != 0)
						quiet_in--;
					else if ($urandom_range(0, 29) == 0)
						quiet_in = $urandom_range(16, 64);
					gap_left = pick_gap(quiet_in != 0);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (blur_if.valid && out_ready) begin
				if (blur_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= MAX_ERR_PRINT)
						$display("%0t: unexpected beat, expected none actual %0d %0d %0d last %0d",
							$time, blur_if.red_out, blur_if.green_out, blur_if.blue_out,
							blur_if.frame_last);
				end else begin
					exp_res = blur_q.pop_front();
					check_field("red_out", exp_res.red, blur_if.red_out);
					check_field("green_out", exp_res.green, blur_if.green_out);
					check_field("blue_out", exp_res.blue, blur_if.blue_out);
					check_field("frame_last", exp_res.last, blur_if.frame_last);
					results_ok++;
					if (exp_res.last)
						frames_done++;
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (quiet_out != 0)
					quiet_out--;
				else if ($urandom_range(0, 29) == 0)
					quiet_out = $urandom_range(16, 64);
				stall_left = pick_gap(quiet_out != 0);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results still expected", cycle_cnt,
				blur_q.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int unsigned w_raw, h_raw, w_eff, h_eff, nframes, stop_at;
		for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
			upper_mem[i] = '0;
			middle_mem[i] = '0;
		end
		for (int i = 0; i < 9; i++)
			win[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// 3x3 frame: extremes, early drain, pixel in the flush, next frame start
		set_frame(3, 3);
		queue_beat('{MODE_PIXEL, CHAN_MAX, CHAN_MAX, CHAN_MAX}, 1'b0);
		queue_beat('{MODE_PIXEL, 8'h00, 8'h00, 8'h00}, 1'b0);
		queue_beat('{MODE_DRAIN, CHAN_MAX, CHAN_MAX, CHAN_MAX}, 1'b0);
		queue_beat('{MODE_PIXEL, CHAN_MAX, 8'h00, CHAN_MAX}, 1'b0);
		queue_beat('{MODE_PIXEL, 8'h00, CHAN_MAX, 8'h00}, 1'b0);
		queue_beat('{MODE_PIXEL, CHAN_MAX, CHAN_MAX, CHAN_MAX}, 1'b0);
		queue_beat('{MODE_PIXEL, CHAN_MAX, CHAN_MAX, CHAN_MAX}, 1'b0);
		queue_beat('{MODE_PIXEL, 8'h01, 8'hFE, 8'h80}, 1'b0);
		queue_beat('{MODE_PIXEL, 8'h00, 8'h00, 8'h00}, 1'b0);
		queue_beat('{MODE_PIXEL, CHAN_MAX, CHAN_MAX, CHAN_MAX}, 1'b0);
		queue_beat('{MODE_DRAIN, 8'h00, 8'h00, 8'h00}, 1'b0);
		queue_beat('{MODE_PIXEL, CHAN_MAX, CHAN_MAX, CHAN_MAX}, 1'b0);
		queue_beat('{MODE_DRAIN, 8'h00, 8'h00, 8'h00}, 1'b0);
		queue_beat('{MODE_DRAIN, 8'h00, 8'h00, 8'h00}, 1'b0);
		queue_beat('{MODE_PIXEL, 8'h00, 8'h00, 8'h00}, 1'b0);
		wait_idle();

		// single pixel frame
		set_frame(1, 1);
		queue_beat('{MODE_PIXEL, CHAN_MAX, CHAN_MAX, CHAN_MAX}, 1'b0);
		queue_beat('{MODE_DRAIN, CHAN_MAX, CHAN_MAX, CHAN_MAX}, 1'b0);
		queue_beat('{MODE_DRAIN, 8'h00, 8'h00, 8'h00}, 1'b0);
		wait_idle();

		// width above the maximum, height zero: the first row is still coming in
		set_frame(2047, 0);
		for (int p = 0; p < 40; p++)
			queue_beat(rand_beat(MODE_PIXEL), 1'b0);
		queue_beat(rand_beat(MODE_DRAIN), 1'b0);
		wait_idle();
		// width zero, height above the maximum: a tall single column, cut short
		set_frame(0, 8191);
		for (int p = 0; p < 60; p++)
			queue_beat(rand_beat(MODE_PIXEL), 1'b0);
		wait_idle();

		while (rand_items < RAND_ITEMS) begin
			case ($urandom_range(0, 11))
				0: w_raw = 0;
				1, 2: w_raw = $urandom_range(9, 40);
				default: w_raw = $urandom_range(1, 8);
			endcase
			case ($urandom_range(0, 11))
				0: h_raw = 0;
				1, 2: h_raw = $urandom_range(6, 12);
				default: h_raw = $urandom_range(1, 5);
			endcase
			w_eff = eff_dim(w_raw, DEF_MAX_WIDTH);
			h_eff = eff_dim(h_raw, DEF_MAX_HEIGHT);
			set_frame(w_raw, h_raw);
			nframes = $urandom_range(1, 3);
			for (int f = 0; f < nframes; f++) begin
				// now and then a frame cut short, abandoned by the next setting
				if ($urandom_range(0, 11) == 0) begin
					stop_at = $urandom_range(0, w_eff * h_eff - 1);
					for (int unsigned p = 0; p < stop_at; p++)
						queue_beat(rand_beat(MODE_PIXEL), 1'b1);
					break;
				end
				queue_frame(w_eff, h_eff, 1'b1, 1'b1);
			end
			wait_idle();
		end

		$display("checked %0d blurred pixels in %0d complete frames", results_ok, frames_done);
		$display("%0d beats sent, %0d register writes, %0d errors", sent_cnt, cfg_writes,
			err_cnt);
		if (err_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/bb3_pkg.sv
rtl/core/bb3_in_if.sv
rtl/core/bb3_out_if.sv
rtl/core/bb3_ram.sv
rtl/core/bb3_ctrl.sv
rtl/core/bb3_dp.sv
rtl/core/box_blur_3x3_stream_core.sv
tb/sv/tb.sv
